// ----- rtl/jvtl_pkg.sv -----
// Shared types, constants and helpers of the joint velocity tracking limiter.
`default_nettype none
package jvtl_pkg;

  localparam int unsigned SqrtSteps = 32;
  localparam logic [15:0] RateReset = 16'd100;
  localparam logic [30:0] AccelReset = 31'd655360;
  localparam logic signed [63:0] Margin = 64'sd66;
  localparam logic signed [63:0] S32Max = 64'sd2147483647;
  localparam logic signed [63:0] S32Min = -64'sd2147483648;

  typedef enum logic {
    REG_RATE  = 1'b0,
    REG_ACCEL = 1'b1
  } reg_idx_t;

  typedef enum logic [1:0] {
    CLAMP_NONE  = 2'd0,
    CLAMP_LOWER = 2'd1,
    CLAMP_UPPER = 2'd2
  } clamp_t;

  typedef struct packed {
    logic signed [31:0] cmd;
    logic signed [31:0] lo_dist;
    logic signed [31:0] hi_dist;
    logic        [30:0] speed;
    logic               lo_neg;
    logic               hi_neg;
  } carry_t;

  function automatic logic signed [31:0] sat32(input logic signed [63:0] v);
    logic signed [31:0] r;
    if (v > S32Max) r = S32Max[31:0];
    else if (v < S32Min) r = S32Min[31:0];
    else r = v[31:0];
    return r;
  endfunction

endpackage
`default_nettype wire

// ----- rtl/jvtl_isqrt.sv -----
// Pipelined integer square root, one result bit per stage.
`default_nettype none
module jvtl_isqrt (
  input  wire logic        clk,
  input  wire logic        en,
  input  wire logic [63:0] rad_i,
  output logic      [31:0] root_o
);

  localparam int unsigned N = jvtl_pkg::SqrtSteps;

  logic [63:0] rad_r  [1:N-1];
  logic [32:0] rem_r  [1:N-1];
  logic [31:0] root_r [1:N];

  for (genvar k = 0; k < N; k++) begin : g_step
    logic [63:0] rad_in;
    logic [32:0] rem_in;
    logic [31:0] root_in;
    logic [34:0] part;
    logic [34:0] trial;
    logic [34:0] diff;
    logic        ge;
    if (k == 0) begin : g_first
      assign rad_in  = rad_i;
      assign rem_in  = '0;
      assign root_in = '0;
    end else begin : g_next
      assign rad_in  = rad_r[k];
      assign rem_in  = rem_r[k];
      assign root_in = root_r[k];
    end
    always_comb begin
      part  = {rem_in, rad_in[63:62]};
      trial = {1'b0, root_in, 2'b01};
      diff  = part - trial;
      ge    = (part >= trial);
    end
    always_ff @(posedge clk) begin
      if (en) root_r[k+1] <= {root_in[30:0], ge};
    end
    if (k < N - 1) begin : g_carry
      always_ff @(posedge clk) begin
        if (en) begin
          rad_r[k+1] <= {rad_in[61:0], 2'b00};
          rem_r[k+1] <= ge ? diff[32:0] : part[32:0];
        end
      end
    end
  end

  assign root_o = root_r[N];

endmodule
`default_nettype wire

// ----- rtl/joint_velocity_tracking_limiter.sv -----
// Top level of the joint velocity tracking limiter pipeline.
// Usage: one word on in_ (in_tvalid/in_tready/in_tdata) per joint carries
// target position and velocity, measured position, position limits, speed cap and gain.
// One word comes out on out_ per input word: out_tdata is the limited
// velocity command, out_tuser holds clamp state and window error.
// Registers control_rate_hz (addr 0) and max_joint_accel (addr 4) sit on
// the cfg_ APB port; write them only while the pipeline is empty.
// An accepted word passes in order through the input, multiply,
// 32-stage square-root, bound and output stages. Throughput is one word
// per cycle while out_tready does not stall the pipeline.
// A stall on out_tready freezes the whole pipeline and drops in_tready
// in the same cycle; nothing is lost or repeated.
// Reset clears all valid bits and loads the register defaults.
`default_nettype none
module joint_velocity_tracking_limiter (
  input  wire logic         clk,
  input  wire logic         rst_n,
  input  wire logic         in_tvalid,
  output logic              in_tready,
  // target_position, target_velocity, measured_position, position_floor,
  // position_ceiling, speed_cap, position_gain, zero pad
  input  wire logic [223:0] in_tdata,
  output logic              out_tvalid,
  input  wire logic         out_tready,
  // velocity_command
  output logic      [31:0]  out_tdata,
  // clamp_state, window_error
  output logic      [2:0]   out_tuser,
  input  wire logic         cfg_psel,
  input  wire logic         cfg_penable,
  input  wire logic         cfg_pwrite,
  input  wire logic [2:0]   cfg_paddr,
  input  wire logic [31:0]  cfg_pwdata,
  output logic      [31:0]  cfg_prdata,
  output logic              cfg_pready
);

  localparam int unsigned N = jvtl_pkg::SqrtSteps;

  logic [15:0] rate_r;
  logic [30:0] accel_r;
  logic        adv;

  assign cfg_pready = 1'b1;
  assign adv        = !out_tvalid || out_tready;
  assign in_tready  = adv;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rate_r  <= jvtl_pkg::RateReset;
      accel_r <= jvtl_pkg::AccelReset;
    end else if (cfg_psel && cfg_penable && cfg_pwrite) begin
      unique case (jvtl_pkg::reg_idx_t'(cfg_paddr[2]))
        jvtl_pkg::REG_RATE:  rate_r  <= cfg_pwdata[15:0];
        jvtl_pkg::REG_ACCEL: accel_r <= cfg_pwdata[30:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (jvtl_pkg::reg_idx_t'(cfg_paddr[2]))
      jvtl_pkg::REG_RATE:  cfg_prdata = {16'd0, rate_r};
      jvtl_pkg::REG_ACCEL: cfg_prdata = {1'b0, accel_r};
      default:             cfg_prdata = '0;
    endcase
  end

  // stage 1: differences
  logic               v1_r;
  logic signed [32:0] err_r, dlo_r, dhi_r;
  logic signed [31:0] tvel_r;
  logic        [30:0] speed1_r, gain_r;

  always_ff @(posedge clk) begin
    if (!rst_n) v1_r <= 1'b0;
    else if (adv) v1_r <= in_tvalid;
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      err_r    <= $signed({in_tdata[31], in_tdata[31:0]})
                - $signed({in_tdata[95], in_tdata[95:64]});
      dlo_r    <= $signed({in_tdata[95], in_tdata[95:64]})
                - $signed({in_tdata[127], in_tdata[127:96]});
      dhi_r    <= $signed({in_tdata[159], in_tdata[159:128]})
                - $signed({in_tdata[95], in_tdata[95:64]});
      tvel_r   <= $signed(in_tdata[63:32]);
      speed1_r <= in_tdata[190:160];
      gain_r   <= in_tdata[221:191];
    end
  end

  // stage 2: products
  logic               v2_r;
  logic signed [63:0] gp_r;
  logic signed [49:0] plo_r, phi_r;
  logic        [63:0] alo_r, ahi_r;
  logic signed [31:0] tvel2_r;
  logic        [30:0] speed2_r;
  logic               lo_neg2_r, hi_neg2_r;
  logic signed [64:0] gp_full;
  logic signed [50:0] plo_full, phi_full;

  always_comb begin
    gp_full  = $signed({1'b0, gain_r}) * err_r;
    plo_full = $signed({1'b0, rate_r}) * dlo_r;
    phi_full = $signed({1'b0, rate_r}) * dhi_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) v2_r <= 1'b0;
    else if (adv) v2_r <= v1_r;
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      gp_r      <= gp_full[63:0];
      plo_r     <= plo_full[49:0];
      phi_r     <= phi_full[49:0];
      alo_r     <= dlo_r[32] ? 64'd0 : {1'b0, accel_r} * {32'd0, dlo_r[31:0]};
      ahi_r     <= dhi_r[32] ? 64'd0 : {1'b0, accel_r} * {32'd0, dhi_r[31:0]};
      tvel2_r   <= tvel_r;
      speed2_r  <= speed1_r;
      lo_neg2_r <= dlo_r[32];
      hi_neg2_r <= dhi_r[32];
    end
  end

  // roots
  logic [31:0] root_lo, root_hi;

  jvtl_isqrt u_sqrt_lo (.clk(clk), .en(adv), .rad_i(alo_r), .root_o(root_lo));
  jvtl_isqrt u_sqrt_hi (.clk(clk), .en(adv), .rad_i(ahi_r), .root_o(root_hi));

  // stage 3 onward: command and distance bounds travel beside the roots
  jvtl_pkg::carry_t   pl_r [1:N];
  logic               vp_r [1:N];
  jvtl_pkg::carry_t   pl_nxt;
  logic signed [48:0] cmd_sum;

  always_comb begin
    cmd_sum        = {{17{tvel2_r[31]}}, tvel2_r} + {{1{gp_r[63]}}, gp_r[63:16]};
    pl_nxt.cmd     = jvtl_pkg::sat32({{15{cmd_sum[48]}}, cmd_sum});
    pl_nxt.lo_dist = jvtl_pkg::sat32(-{{14{plo_r[49]}}, plo_r});
    pl_nxt.hi_dist = jvtl_pkg::sat32({{14{phi_r[49]}}, phi_r});
    pl_nxt.speed   = speed2_r;
    pl_nxt.lo_neg  = lo_neg2_r;
    pl_nxt.hi_neg  = hi_neg2_r;
  end

  for (genvar k = 1; k <= N; k++) begin : g_carry
    if (k == 1) begin : g_head
      always_ff @(posedge clk) begin
        if (!rst_n) vp_r[k] <= 1'b0;
        else if (adv) vp_r[k] <= v2_r;
      end
      always_ff @(posedge clk) begin
        if (adv) pl_r[k] <= pl_nxt;
      end
    end else begin : g_tail
      always_ff @(posedge clk) begin
        if (!rst_n) vp_r[k] <= 1'b0;
        else if (adv) vp_r[k] <= vp_r[k-1];
      end
      always_ff @(posedge clk) begin
        if (adv) pl_r[k] <= pl_r[k-1];
      end
    end
  end

  // window
  logic               vf_r;
  logic signed [31:0] lower_r, upper_r, cmdf_r;
  logic signed [31:0] lower_nxt, upper_nxt, neg_speed, rlo_b, rhi_b;

  always_comb begin
    jvtl_pkg::carry_t p;
    p         = pl_r[N];
    neg_speed = -$signed({1'b0, p.speed});
    rlo_b     = jvtl_pkg::sat32(-$signed({31'd0, root_lo, 1'b0}));
    rhi_b     = jvtl_pkg::sat32($signed({31'd0, root_hi, 1'b0}));
    lower_nxt = p.lo_dist;
    if (neg_speed > lower_nxt) lower_nxt = neg_speed;
    if (!p.lo_neg && rlo_b > lower_nxt) lower_nxt = rlo_b;
    upper_nxt = p.hi_dist;
    if ($signed({1'b0, p.speed}) < upper_nxt) upper_nxt = $signed({1'b0, p.speed});
    if (!p.hi_neg && rhi_b < upper_nxt) upper_nxt = rhi_b;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) vf_r <= 1'b0;
    else if (adv) vf_r <= vp_r[N];
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      lower_r <= lower_nxt;
      upper_r <= upper_nxt;
      cmdf_r  <= pl_r[N].cmd;
    end
  end

  // clamp and output word
  logic              out_valid_r;
  logic       [31:0] out_data_r, out_data_nxt;
  jvtl_pkg::clamp_t  clamp_r, clamp_nxt;
  logic              werr_r, werr_nxt;

  always_comb begin
    werr_nxt     = 1'b0;
    clamp_nxt    = jvtl_pkg::CLAMP_NONE;
    out_data_nxt = cmdf_r;
    priority if (lower_r > upper_r) begin
      werr_nxt     = 1'b1;
      out_data_nxt = '0;
    end else if (cmdf_r <= lower_r) begin
      clamp_nxt    = jvtl_pkg::CLAMP_LOWER;
      out_data_nxt = jvtl_pkg::sat32({{32{lower_r[31]}}, lower_r} + jvtl_pkg::Margin);
    end else if (cmdf_r >= upper_r) begin
      clamp_nxt    = jvtl_pkg::CLAMP_UPPER;
      out_data_nxt = jvtl_pkg::sat32({{32{upper_r[31]}}, upper_r} - jvtl_pkg::Margin);
    end else begin
      out_data_nxt = cmdf_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) out_valid_r <= 1'b0;
    else if (adv) out_valid_r <= vf_r;
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      out_data_r <= out_data_nxt;
      clamp_r    <= clamp_nxt;
      werr_r     <= werr_nxt;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;
  assign out_tuser  = {werr_r, clamp_r};

endmodule
`default_nettype wire
